@@ rtl/assert_macros.svh @@
// Assertion macros used by the LED pattern generator controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define LPG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset as well
`define LPG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/lpg_pkg.sv @@
// Types, constants and helpers for the LED pattern generator
package lpg_pkg;

    localparam int TIME_BITS_DEF = 32;

    localparam int PERIOD_W  = 16;
    localparam int DUTY_W    = 8;
    localparam int MODE_W    = 3;
    localparam int ELAPSED_W = 16;
    localparam int ALT_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Fixed-point blink threshold and heartbeat percentages
    localparam int DUTY_SHIFT  = 8;
    localparam int PCT_SCALE   = 100;
    localparam int HB_ON1_PCT  = 15;
    localparam int HB_OFF_PCT  = 30;
    localparam int HB_ON2_PCT  = 45;
    localparam int PCT_PROD_W  = 23;
    localparam int DUTY_PROD_W = PERIOD_W + DUTY_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF   = 3'd0,
        MODE_ON    = 3'd1,
        MODE_BLINK = 3'd2,
        MODE_HEART = 3'd3
    } t_mode;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_START = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAIN_MODE   = 3'd0,
        CFG_MAIN_PERIOD = 3'd1,
        CFG_MAIN_DUTY   = 3'd2,
        CFG_ALT_PATTERN = 3'd3,
        CFG_ALT_PERIOD  = 3'd4,
        CFG_ALT_THRESH  = 3'd5
    } t_cfg_idx;

    localparam logic [MODE_W-1:0]   MAIN_MODE_RST   = 3'd2;
    localparam logic [PERIOD_W-1:0] MAIN_PERIOD_RST = 16'd1000;
    localparam logic [DUTY_W-1:0]   MAIN_DUTY_RST   = 8'd128;
    localparam logic [MODE_W-1:0]   ALT_PATTERN_RST = 3'd2;
    localparam logic [PERIOD_W-1:0] ALT_PERIOD_RST  = 16'd1000;
    localparam logic [DUTY_W-1:0]   ALT_THRESH_RST  = 8'd128;

    typedef struct packed {
        logic [MODE_W-1:0]   main_mode;
        logic [PERIOD_W-1:0] main_period;
        logic [DUTY_W-1:0]   main_duty;
        logic [MODE_W-1:0]   alt_pattern;
        logic [PERIOD_W-1:0] alt_period;
        logic [DUTY_W-1:0]   alt_thresh;
    } t_cfg;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic tick;
        logic start;
        logic div_step;
        logic eval;
        logic push;
    } t_ctrl_cmd;

    // A zero period behaves as one millisecond
    function automatic logic [PERIOD_W-1:0] eff_period(input logic [PERIOD_W-1:0] p);
        return (p == '0) ? PERIOD_W'(1) : p;
    endfunction

endpackage

@@ rtl/lpg_if.sv @@
// Stream and configuration interfaces of the LED pattern generator
interface lpg_in_if import lpg_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic [ALT_W-1:0]     alt_duration_ms;

    modport source (output valid, cmd, elapsed_ms, alt_duration_ms, input ready);
    modport sink   (input valid, cmd, elapsed_ms, alt_duration_ms, output ready);
endinterface

interface lpg_out_if;
    logic valid;
    logic ready;
    logic led_on;
    logic alt_active;

    modport source (output valid, led_on, alt_active, input ready);
    modport sink   (input valid, led_on, alt_active, output ready);
endinterface

interface lpg_cfg_if import lpg_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/led_pattern_generator.sv @@
// A tick beat runs the remainder divider, evaluates the LED level and then pushes the result;
// a start beat loads the alternate timeout and goes straight to the push. No new beat is taken
//   until the last one is pushed; the remainder divider retires one time bit a cycle.
// A finished result waits in the output register while the next beat is taken.
// Reset (synchronous, active low): time, timeout and LED level clear to zero, the
//   registers take their defaults, and the block is ready at once.
module led_pattern_generator import lpg_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lpg_in_if.sink     i_in,
    lpg_out_if.source  o_out,
    lpg_cfg_if.sink    i_cfg
);

    t_cfg      r_cfg;
    t_ctrl_cmd w_cmd;

    // Configuration beats are always taken; an index past the list is dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.main_mode   <= MAIN_MODE_RST;
            r_cfg.main_period <= MAIN_PERIOD_RST;
            r_cfg.main_duty   <= MAIN_DUTY_RST;
            r_cfg.alt_pattern <= ALT_PATTERN_RST;
            r_cfg.alt_period  <= ALT_PERIOD_RST;
            r_cfg.alt_thresh  <= ALT_THRESH_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_MAIN_MODE:   r_cfg.main_mode   <= i_cfg.data[MODE_W-1:0];
                CFG_MAIN_PERIOD: r_cfg.main_period <= i_cfg.data[PERIOD_W-1:0];
                CFG_MAIN_DUTY:   r_cfg.main_duty   <= i_cfg.data[DUTY_W-1:0];
                CFG_ALT_PATTERN: r_cfg.alt_pattern <= i_cfg.data[MODE_W-1:0];
                CFG_ALT_PERIOD:  r_cfg.alt_period  <= i_cfg.data[PERIOD_W-1:0];
                CFG_ALT_THRESH:  r_cfg.alt_thresh  <= i_cfg.data[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Controller: accept, run the divider, evaluate the level, hand over the result
    lpg_ctrl #(
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_cmd    (i_in.cmd),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd)
    );

    // Datapath: time base, alternate timeout, phase remainder and pattern level
    lpg_dp #(
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_cfg             (r_cfg),
        .i_elapsed_ms      (i_in.elapsed_ms),
        .i_alt_duration_ms (i_in.alt_duration_ms),
        .o_led_on          (o_out.led_on),
        .o_alt_active      (o_out.alt_active)
    );

endmodule

@@ rtl/lpg_ctrl.sv @@
// Sequencing controller of the LED pattern generator
`include "assert_macros.svh"

module lpg_ctrl import lpg_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_cmd,
    output logic      o_in_ready,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_ctrl_cmd o_cmd
);

    localparam int CNT_W = $clog2(TIME_BITS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_EVAL = 4'b0100,
        S_PUSH = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_cmd == CMD_START) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_PUSH;
                    end else begin
                        o_cmd.tick = 1'b1;
                        n_cnt      = CNT_W'(TIME_BITS - 1);
                        n_state    = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_EVAL;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_PUSH;
            end
            S_PUSH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.push) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `LPG_ASSERT(a_push_no_overwrite, i_clk, i_rst_n, o_cmd.push |-> (!r_out_valid || i_out_ready), "result register overwritten while full")
    `LPG_ASSERT(a_tick_loads_count, i_clk, i_rst_n, o_cmd.tick |=> (r_state == S_DIV && r_cnt == CNT_W'(TIME_BITS - 1)), "tick did not start a full division")
    `LPG_ASSERT(a_div_ends_eval, i_clk, i_rst_n, (r_state == S_DIV && r_cnt == '0) |=> (r_state == S_EVAL), "division did not hand over to evaluation")
    `LPG_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE && !r_out_valid), "reset did not return to idle")

endmodule

@@ rtl/lpg_dp.sv @@
// Datapath of the LED pattern generator: time, timeout, phase divider, level
module lpg_dp import lpg_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl_cmd            i_cmd,
    input  t_cfg                 i_cfg,
    input  logic [ELAPSED_W-1:0] i_elapsed_ms,
    input  logic [ALT_W-1:0]     i_alt_duration_ms,
    output logic                 o_led_on,
    output logic                 o_alt_active
);

    logic [TIME_BITS-1:0] r_time;
    logic [TIME_BITS-1:0] r_dividend;
    logic [PERIOD_W-1:0]  r_rem;
    logic [ALT_W-1:0]     r_alt_rem;
    logic                 r_use_alt;
    logic                 r_led;
    logic                 r_out_led;
    logic                 r_out_alt;

    logic [TIME_BITS-1:0]   w_time_sum;
    logic [ALT_W-1:0]       w_dt_ext;
    logic [ALT_W-1:0]       w_alt_next;
    logic [PERIOD_W-1:0]    w_period;
    logic [DUTY_W-1:0]      w_duty;
    logic [MODE_W-1:0]      w_mode;
    logic [PERIOD_W:0]      w_trial;
    logic [PERIOD_W:0]      w_trial_sub;
    logic [DUTY_PROD_W-1:0] w_duty_prod;
    logic [PERIOD_W-1:0]    w_blink_thr;
    logic [PCT_PROD_W-1:0]  w_phase_pct;
    logic [PCT_PROD_W-1:0]  w_p_on1;
    logic [PCT_PROD_W-1:0]  w_p_off;
    logic [PCT_PROD_W-1:0]  w_p_on2;
    logic                   w_blink_lit;
    logic                   w_heart_lit;
    logic                   w_level;

    assign w_time_sum = r_time + TIME_BITS'(i_elapsed_ms);
    assign w_dt_ext   = ALT_W'(i_elapsed_ms);
    assign w_alt_next = (r_alt_rem <= w_dt_ext) ? '0 : (r_alt_rem - w_dt_ext);

    // Pattern selection latched at the tick
    assign w_period = r_use_alt ? eff_period(i_cfg.alt_period) : eff_period(i_cfg.main_period);
    assign w_duty   = r_use_alt ? i_cfg.alt_thresh : i_cfg.main_duty;
    assign w_mode   = r_use_alt ? i_cfg.alt_pattern : i_cfg.main_mode;

    // Restoring division, one quotient bit a cycle; only the remainder is kept
    assign w_trial     = {r_rem, r_dividend[TIME_BITS-1]};
    assign w_trial_sub = w_trial - {1'b0, w_period};

    assign w_duty_prod = DUTY_PROD_W'(w_period) * DUTY_PROD_W'(w_duty);
    assign w_blink_thr = PERIOD_W'(w_duty_prod >> DUTY_SHIFT);
    assign w_blink_lit = (r_rem > w_blink_thr);

    // phase <= floor(p*k/100) is the same as 100*phase <= p*k
    assign w_phase_pct = PCT_PROD_W'(r_rem) * PCT_PROD_W'(PCT_SCALE);
    assign w_p_on1     = PCT_PROD_W'(w_period) * PCT_PROD_W'(HB_ON1_PCT);
    assign w_p_off     = PCT_PROD_W'(w_period) * PCT_PROD_W'(HB_OFF_PCT);
    assign w_p_on2     = PCT_PROD_W'(w_period) * PCT_PROD_W'(HB_ON2_PCT);
    assign w_heart_lit = ((r_rem != '0) && (w_phase_pct <= w_p_on1))
                      || ((w_phase_pct > w_p_off) && (w_phase_pct <= w_p_on2));

    always_comb begin
        unique case (w_mode)
            MODE_ON:    w_level = 1'b1;
            MODE_BLINK: w_level = w_blink_lit;
            MODE_HEART: w_level = !r_use_alt && w_heart_lit;
            default:    w_level = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time    <= '0;
            r_alt_rem <= '0;
            r_led     <= 1'b0;
        end else begin
            if (i_cmd.tick) begin
                r_time <= w_time_sum;
                if (r_alt_rem != '0) begin
                    r_alt_rem <= w_alt_next;
                end
            end
            if (i_cmd.start) begin
                r_alt_rem <= i_alt_duration_ms;
            end
            if (i_cmd.eval) begin
                r_led <= w_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick) begin
            r_dividend <= w_time_sum;
            r_rem      <= '0;
            r_use_alt  <= (r_alt_rem != '0);
        end
        if (i_cmd.div_step) begin
            r_dividend <= r_dividend << 1;
            if (!w_trial_sub[PERIOD_W]) begin
                r_rem <= w_trial_sub[PERIOD_W-1:0];
            end else begin
                r_rem <= w_trial[PERIOD_W-1:0];
            end
        end
        if (i_cmd.push) begin
            r_out_led <= r_led;
            r_out_alt <= (r_alt_rem != '0);
        end
    end

    assign o_led_on     = r_out_led;
    assign o_alt_active = r_out_alt;

endmodule
